/* rtl/pks_pkg.sv */
// Shared types, constants and the key compare for the pair key sorter.
package pks_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } pks_status_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     row;
        logic [KEY_BITS-1:0]     col;
        logic [PAYLOAD_BITS-1:0] payload;
    } pks_entry_t;

    // Command broadcast to every cell in the same cycle.
    typedef struct packed {
        logic       ins;
        logic       drn;
        pks_entry_t entry;
    } pks_cmd_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic       valid;
        logic       place;
        pks_entry_t entry;
    } pks_link_t;

    // True when key (r1, c1) sorts strictly before key (r2, c2).
    function automatic logic key_before(
        input logic [KEY_BITS-1:0] r1,
        input logic [KEY_BITS-1:0] c1,
        input logic [KEY_BITS-1:0] r2,
        input logic [KEY_BITS-1:0] c2
    );
        logic res;
        if (r1 == r2) begin
            res = (c1 < c2);
        end else begin
            res = (r1 < r2);
        end
        return res;
    endfunction

endpackage

/* rtl/pks_cell.sv */
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module pks_cell
    import pks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pks_cmd_t  cmd,
    input  pks_link_t left_link,
    input  pks_link_t right_link,
    output pks_link_t link
);

    logic       valid_reg;
    logic       valid_next;
    pks_entry_t entry_reg;
    pks_entry_t entry_next;
    logic       after;
    logic       place;

    // The new key goes at or before this slot when the slot is empty or holds
    // a strictly larger key; equal keys stay ahead of the new one.
    assign after = valid_reg && key_before(cmd.entry.row, cmd.entry.col,
                                           entry_reg.row, entry_reg.col);
    assign place = !valid_reg || after;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.ins && place) begin
            if (left_link.place) begin
                valid_next = left_link.valid;
                entry_next = left_link.entry;
            end else begin
                valid_next = 1'b1;
                entry_next = cmd.entry;
            end
        end else if (cmd.drn) begin
            valid_next = right_link.valid;
            entry_next = right_link.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.valid = valid_reg;
    assign link.place = place;
    assign link.entry = entry_reg;

endmodule

/* rtl/pair_key_sorter.sv */
// Top level of the pair key sorter: a chain of sorting cells and the output stage.
//
// The pair key sorter keeps up to 1024 entries ordered by row key, then by
// column key, both ascending; each entry carries a 64-bit payload that moves
// with its key untouched. A transaction with mode 0 inserts its entry after
// every stored entry with an equal key, so equal keys leave in arrival order;
// an insert into a full store is dropped and answered with status 1. A
// transaction with mode 1 drains the smallest entry, with last set when the
// store is empty afterwards, or answers status 2 when there was nothing to
// drain. A successful insert gives no result. In each transaction the key is
// broadcast to all cells of the chain, each compares it with its own entry,
// and the whole row shifts right (insert) or left (drain) in the same clock
// edge. Results sit in one output register; a new transaction is taken in
// every cycle in which that register is empty or being emptied, so the
// sustained rate is one transaction per cycle as long as out_stall is low.
// The store needs no clearing after reset: each cell has a valid bit.
module pair_key_sorter
    import pks_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic [KEY_BITS-1:0]     row_key,
    input  logic [KEY_BITS-1:0]     col_key,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [KEY_BITS-1:0]     out_row,
    output logic [KEY_BITS-1:0]     out_col,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic                    last,
    output logic [1:0]              status
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    pks_entry_t         out_entry_reg;
    pks_entry_t         out_entry_next;
    logic               last_reg;
    logic               last_next;
    pks_status_t        status_reg;
    pks_status_t        status_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    pks_cmd_t   cmd;
    pks_link_t  cell_link [CAPACITY];
    pks_link_t  edge_link;

    // The input waits only while a result is held and the far side stalls.
    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign is_full = (count_reg == CAP_COUNT);
    assign is_empty = (count_reg == '0);

    assign cmd.ins = accept && (mode == MODE_INSERT) && !is_full;
    assign cmd.drn = accept && (mode == MODE_DRAIN) && !is_empty;
    assign cmd.entry.row = row_key;
    assign cmd.entry.col = col_key;
    assign cmd.entry.payload = payload;

    // Both ends of the chain see an empty neighbor that never takes the new
    // entry, so the head cell takes the key itself and the tail shifts in
    // an empty slot on drain.
    assign edge_link.valid = 1'b0;
    assign edge_link.place = 1'b0;
    assign edge_link.entry = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        pks_link_t left_in;
        pks_link_t right_in;

        if (i == 0) begin : g_head
            assign left_in = edge_link;
        end else begin : g_body_left
            assign left_in = cell_link[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_in = edge_link;
        end else begin : g_body_right
            assign right_in = cell_link[i+1];
        end

        pks_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_link  (left_in),
            .right_link (right_in),
            .link       (cell_link[i])
        );
    end

    // Entry count and the result register.
    always_comb
    begin
        count_next = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_entry_next = out_entry_reg;
        last_next = last_reg;
        status_next = status_reg;

        if (cmd.ins) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (cmd.drn) begin
            count_next = count_reg - COUNT_W'(1);
        end

        if (accept) begin
            if (mode == MODE_INSERT) begin
                if (is_full) begin
                    out_valid_next = 1'b1;
                    out_entry_next = '0;
                    last_next = 1'b0;
                    status_next = STATUS_FULL;
                end
            end else begin
                out_valid_next = 1'b1;
                if (is_empty) begin
                    out_entry_next = '0;
                    last_next = 1'b0;
                    status_next = STATUS_EMPTY;
                end else begin
                    out_entry_next = cell_link[0].entry;
                    last_next = (count_reg == COUNT_W'(1));
                    status_next = STATUS_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg <= out_entry_next;
        last_reg <= last_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row = out_entry_reg.row;
    assign out_col = out_entry_reg.col;
    assign out_payload = out_entry_reg.payload;
    assign last = last_reg;
    assign status = status_reg;

endmodule

/* rtl/pks_checker.sv */
// Port-level checks for the pair key sorter and the bind that attaches them.
module pks_checker
    import pks_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    mode,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    last,
    input logic [1:0]              status
);

    // A held result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

    // Every accepted drain answers in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_DRAIN) |=> out_valid)
    else $error("drain transaction gave no result");

    // The empty flag only comes with a delivered entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (status == STATUS_OK))
    else $error("last set on a status result");

    // Status carries only defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_FULL)
                      || (status == STATUS_EMPTY))
    else $error("undefined status code");

endmodule

bind pair_key_sorter pks_checker u_pks_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last),
    .status    (status)
);
